@@ rtl/rfalu_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rfalu_pkg: shared types and constants of the register file alu core
// operation codes, beat layout and flag masks used by the core
// ---------------------------------------------------------------------------
package rfalu_pkg;

    // default number of registers in the file
    localparam int REG_COUNT_DEF = 8;

    // field widths
    localparam int DATA_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 3;
    localparam int OP_W    = 2;

    // packed beat widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // sign masks for the two operand sizes
    localparam logic [DATA_W-1:0] SIGN_MASK_WORD = 16'h8000;
    localparam logic [DATA_W-1:0] SIGN_MASK_BYTE = 16'h0080;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_MOV = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_CMP = 2'd3
    } op_t;

    // one decoded instruction beat
    typedef struct packed {
        op_t                operation;
        logic               wide;
        logic [INDEX_W-1:0] dst_index;
        logic               dst_high;
        logic               src_is_immediate;
        logic [INDEX_W-1:0] src_index;
        logic               src_high;
        logic [DATA_W-1:0]  immediate;
    } beat_t;

endpackage
`default_nettype wire

@@ rtl/reg_file_alu_mov_add_sub_cmp_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// reg_file_alu_mov_add_sub_cmp_core: register file with mov/add/sub/cmp alu
// executes one instruction per beat on a file of 16-bit registers and keeps
// the zero and sign flags
// ---------------------------------------------------------------------------
//
// channel  dir  payload                                         handshake
// s_       in   instruction (operation .. immediate), 28 bits   s_tvalid/s_tready
// m_       out  result_value, zero_flag, sign_flag, 18 bits     m_tvalid/m_tready
//
// one instruction per cycle sustained while the result is not stalled; an accepted
// beat passes through the input register, then the result register
// register operands are read from the file when the beat is accepted, with a
// bypass from the instruction writing back in the same cycle
// aresetn clears the flags, the register valid bits and the handshake state;
// the file reads as zero until written, so no clearing pass is needed
// a stalled result holds; the input register keeps accepting while the result
// register is free or being drained
//
module reg_file_alu_mov_add_sub_cmp_core #(
    parameter int REG_COUNT = rfalu_pkg::REG_COUNT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // fields from bit 0 up: operation[1:0], wide[2], dst_index[5:3],
    // dst_high[6], src_is_immediate[7], src_index[10:8], src_high[11],
    // immediate[27:12], zero pad[31:28]
    input  wire logic [rfalu_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // fields from bit 0 up: result_value[15:0], zero_flag[16], sign_flag[17],
    // zero pad[23:18]
    output logic [rfalu_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready
);

    localparam int ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DW     = rfalu_pkg::DATA_W;
    localparam int BW     = rfalu_pkg::BYTE_W;

    // unpack the incoming beat
    rfalu_pkg::beat_t s_beat;
    always_comb begin
        s_beat.operation        = rfalu_pkg::op_t'(s_tdata[1:0]);
        s_beat.wide             = s_tdata[2];
        s_beat.dst_index        = s_tdata[5:3];
        s_beat.dst_high         = s_tdata[6];
        s_beat.src_is_immediate = s_tdata[7];
        s_beat.src_index        = s_tdata[10:8];
        s_beat.src_high         = s_tdata[11];
        s_beat.immediate        = s_tdata[27:12];
    end

    // pipeline registers
    rfalu_pkg::beat_t  in_beat_reg;
    logic              in_valid_reg;
    logic              in_dst_ok_reg;
    logic [DW-1:0]     rd_dst_reg;
    logic [DW-1:0]     rd_src_reg;
    logic              out_valid_reg;
    logic [DW-1:0]     out_value_reg;
    logic              out_zero_reg;
    logic              out_sign_reg;
    logic              zero_bit_reg;
    logic              sign_bit_reg;

    // register file and its valid bits
    logic [DW-1:0]        rf_mem_reg [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;

    // handshake control
    logic s_fire;
    logic advance;
    logic exec_fire;

    assign advance   = !out_valid_reg || m_tready;
    assign exec_fire = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;

    // read addresses and range checks at accept time
    logic              dst_ok;
    logic              src_ok;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_addr;

    assign dst_ok   = (32'(s_beat.dst_index) < REG_COUNT);
    assign src_ok   = (32'(s_beat.src_index) < REG_COUNT);
    assign dst_addr = ADDR_W'(s_beat.dst_index);
    assign src_addr = ADDR_W'(s_beat.src_index);

    // execute: operand selection
    logic [DW-1:0] src_val;
    logic [DW-1:0] op_a;
    logic [DW-1:0] op_b;
    logic [DW-1:0] alu_raw;
    logic [DW-1:0] alu_res;
    logic [DW-1:0] wb_val;
    logic          res_zero;
    logic          res_sign;

    always_comb begin
        src_val = in_beat_reg.src_is_immediate ? in_beat_reg.immediate : rd_src_reg;
        if (in_beat_reg.wide) begin
            op_a = rd_dst_reg;
            op_b = src_val;
        end else begin
            op_a = {{(DW-BW){1'b0}},
                    in_beat_reg.dst_high ? rd_dst_reg[DW-1:BW] : rd_dst_reg[BW-1:0]};
            op_b = {{(DW-BW){1'b0}},
                    (in_beat_reg.src_high && !in_beat_reg.src_is_immediate)
                        ? src_val[DW-1:BW] : src_val[BW-1:0]};
        end
    end

    // execute: alu
    always_comb begin
        unique case (in_beat_reg.operation)
            rfalu_pkg::OP_MOV: alu_raw = op_b;
            rfalu_pkg::OP_ADD: alu_raw = op_a + op_b;
            default:           alu_raw = op_a - op_b;
        endcase
        alu_res  = in_beat_reg.wide ? alu_raw : {{(DW-BW){1'b0}}, alu_raw[BW-1:0]};
        res_zero = (alu_res == '0);
        res_sign = in_beat_reg.wide ? ((alu_res & rfalu_pkg::SIGN_MASK_WORD) != '0)
                                    : ((alu_res & rfalu_pkg::SIGN_MASK_BYTE) != '0);
    end

    // execute: write-back value merges the byte into the old register
    always_comb begin
        if (in_beat_reg.wide) begin
            wb_val = alu_res;
        end else if (in_beat_reg.dst_high) begin
            wb_val = {alu_res[BW-1:0], rd_dst_reg[BW-1:0]};
        end else begin
            wb_val = {rd_dst_reg[DW-1:BW], alu_res[BW-1:0]};
        end
    end

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              flag_upd;

    assign wr_en    = exec_fire && in_dst_ok_reg && (in_beat_reg.operation != rfalu_pkg::OP_CMP);
    assign wr_addr  = ADDR_W'(in_beat_reg.dst_index);
    assign flag_upd = exec_fire && (in_beat_reg.operation != rfalu_pkg::OP_MOV);

    // register file write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf_mem_reg[wr_addr] <= wb_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (wr_en) begin
            rf_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // register file read with write bypass, captured with the beat
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_beat_reg   <= s_beat;
            in_dst_ok_reg <= dst_ok;
            if (!dst_ok) begin
                rd_dst_reg <= '0;
            end else if (wr_en && (wr_addr == dst_addr)) begin
                rd_dst_reg <= wb_val;
            end else if (!rf_valid_reg[dst_addr]) begin
                rd_dst_reg <= '0;
            end else begin
                rd_dst_reg <= rf_mem_reg[dst_addr];
            end
            if (!src_ok) begin
                rd_src_reg <= '0;
            end else if (wr_en && (wr_addr == src_addr)) begin
                rd_src_reg <= wb_val;
            end else if (!rf_valid_reg[src_addr]) begin
                rd_src_reg <= '0;
            end else begin
                rd_src_reg <= rf_mem_reg[src_addr];
            end
        end
    end

    // flags
    logic zero_next;
    logic sign_next;

    assign zero_next = flag_upd ? res_zero : zero_bit_reg;
    assign sign_next = flag_upd ? res_sign : sign_bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_bit_reg <= 1'b0;
            sign_bit_reg <= 1'b0;
        end else begin
            zero_bit_reg <= zero_next;
            sign_bit_reg <= sign_next;
        end
    end

    // valid bits of both stages
    logic in_valid_next;
    logic out_valid_next;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (exec_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (exec_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            out_value_reg <= alu_res;
            out_zero_reg  <= zero_next;
            out_sign_reg  <= sign_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rfalu_pkg::M_TDATA_W-DW-2){1'b0}},
                       out_sign_reg, out_zero_reg, out_value_reg};

`ifndef SYNTH
    // cmp never writes the register file
    a_cmp_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (in_beat_reg.operation != rfalu_pkg::OP_CMP))
        else $error("cmp wrote the register file");

    // mov leaves the stored flags alone
    a_mov_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && (in_beat_reg.operation == rfalu_pkg::OP_MOV))
        |=> (zero_bit_reg == $past(zero_bit_reg)) && (sign_bit_reg == $past(sign_bit_reg)))
        else $error("mov changed the flags");

    // an executed instruction shows up as a result beat with the stored flags
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_tvalid && (out_zero_reg == zero_bit_reg)
                      && (out_sign_reg == sign_bit_reg))
        else $error("result beat does not match executed instruction");

    // a held instruction only waits on a stalled result
    a_hold_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !exec_fire) |-> (out_valid_reg && !m_tready))
        else $error("instruction held without a stalled result");
`endif

endmodule
`default_nettype wire
